// File: design/hebp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hebp_pkg;

  // Table geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 31;
  localparam int SYM_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);

  // Field widths fixed by the interface
  localparam int MODE_W  = 2;
  localparam int SYMIN_W = 8;
  localparam int CNT_W   = 6;
  localparam int VAL_W   = 32;
  localparam int BYTE_W  = 8;

  // Packer sizing: up to seven pending bits plus one full raw run
  localparam int RAW_MAX = 32;
  localparam int BUF_W   = BYTE_W - 1;
  localparam int WORK_W  = BUF_W + RAW_MAX;

  // Queue between the lookup front and the packer
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_RAW    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [SYMIN_W-1:0] symbol;
    logic [CNT_W-1:0]   bit_count;
    logic [VAL_W-1:0]   bit_value;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_t;

  // One unit of work for the packer: append bits, or pad to a byte boundary
  typedef struct packed {
    logic             pad;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] bits;
  } chunk_t;

  typedef struct packed {
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] code;
  } entry_t;

  // Mask of the low n bits, n up to RAW_MAX
  function automatic logic [VAL_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [VAL_W-1:0] ones;
    ones = '1;
    if (n >= CNT_W'(RAW_MAX)) begin
      return ones;
    end
    return ~(ones << n);
  endfunction

endpackage

`default_nettype wire

// File: design/hebp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hebp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire hebp_pkg::in_t   item,
  output logic                 chunk_valid,
  output hebp_pkg::chunk_t     chunk,
  input  wire logic            q_ready
);

  // Code table: memory plus one valid bit per entry
  hebp_pkg::entry_t                    code_mem [hebp_pkg::SYMBOL_COUNT];
  logic [hebp_pkg::SYMBOL_COUNT-1:0]   entry_ok;
  hebp_pkg::entry_t                    rd_entry;
  logic                                rd_hit;

  // Lookup stage registers
  logic                                s1_valid;
  hebp_pkg::mode_t                     s1_mode;
  logic                                s1_sym_ok;
  logic [hebp_pkg::CNT_W-1:0]          s1_count;
  logic [hebp_pkg::VAL_W-1:0]          s1_bits;

  logic                                accept;
  logic                                sym_ok;
  logic [hebp_pkg::SYM_W-1:0]          idx;
  logic [hebp_pkg::LEN_W-1:0]          len_sat;
  logic [hebp_pkg::CNT_W-1:0]          raw_cnt;
  logic                                s1_free;
  logic [hebp_pkg::CNT_W-1:0]          c_count;
  logic [hebp_pkg::VAL_W-1:0]          c_bits;
  logic                                c_pad;
  logic                                c_live;

  // Input decode
  assign sym_ok  = {1'b0, item.symbol} < (hebp_pkg::SYMIN_W + 1)'(hebp_pkg::SYMBOL_COUNT);
  assign idx     = item.symbol[hebp_pkg::SYM_W-1:0];
  assign len_sat = (item.bit_count > hebp_pkg::CNT_W'(hebp_pkg::MAX_CODE_LEN))
                   ? hebp_pkg::LEN_W'(hebp_pkg::MAX_CODE_LEN)
                   : item.bit_count[hebp_pkg::LEN_W-1:0];
  assign raw_cnt = (item.bit_count > hebp_pkg::CNT_W'(hebp_pkg::RAW_MAX))
                   ? hebp_pkg::CNT_W'(hebp_pkg::RAW_MAX) : item.bit_count;

  assign s1_free = !s1_valid || !chunk_valid || q_ready;
  assign full    = !s1_free;
  assign accept  = push && !full;

  // Table write on load, registered read on every in-range beat
  always_ff @(posedge clk) begin
    if (accept && sym_ok) begin
      if (item.mode == hebp_pkg::MODE_LOAD) begin
        code_mem[idx] <= '{len: len_sat,
                           code: item.bit_value[hebp_pkg::MAX_CODE_LEN-1:0]};
      end
      rd_entry <= code_mem[idx];
    end
  end

  // Entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      rd_hit   <= 1'b0;
    end else if (accept && sym_ok) begin
      rd_hit <= entry_ok[idx];
      if (item.mode == hebp_pkg::MODE_LOAD) begin
        entry_ok[idx] <= 1'b1;
      end
    end
  end

  // Lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_free) begin
      s1_valid <= 1'b0;
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= item.mode;
      s1_sym_ok <= sym_ok;
      s1_count  <= raw_cnt;
      s1_bits   <= item.bit_value;
    end
  end

  // Turn the item into packer work
  always_comb begin
    c_pad   = 1'b0;
    c_count = '0;
    c_bits  = '0;
    c_live  = 1'b0;
    case (s1_mode)
      hebp_pkg::MODE_ENCODE: begin
        if (s1_sym_ok && rd_hit) begin
          c_count = hebp_pkg::CNT_W'(rd_entry.len);
        end
        c_bits = hebp_pkg::VAL_W'(rd_entry.code) & hebp_pkg::low_mask(c_count);
        c_live = c_count != '0;
      end
      hebp_pkg::MODE_RAW: begin
        c_count = s1_count;
        c_bits  = s1_bits & hebp_pkg::low_mask(s1_count);
        c_live  = s1_count != '0;
      end
      hebp_pkg::MODE_FLUSH: begin
        c_pad  = 1'b1;
        c_live = 1'b1;
      end
      default: begin
        c_live = 1'b0;
      end
    endcase
  end

  assign chunk_valid = s1_valid && c_live;
  assign chunk       = '{pad: c_pad, count: c_count, bits: c_bits};

endmodule

`default_nettype wire

// File: design/hebp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hebp_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  input  wire hebp_pkg::chunk_t  wr_data,
  output logic                   wr_ready,
  output logic                   rd_valid,
  output hebp_pkg::chunk_t       rd_data,
  input  wire logic              rd_pop
);

  hebp_pkg::chunk_t           slots [hebp_pkg::QUEUE_DEPTH];
  logic [hebp_pkg::QA_W-1:0]  wr_ptr;
  logic [hebp_pkg::QA_W-1:0]  rd_ptr;
  logic [hebp_pkg::QA_W:0]    fill;
  logic                       do_wr;
  logic                       do_rd;

  // Ready looks only at registered fill, so no path from the pop side
  assign wr_ready = fill != (hebp_pkg::QA_W + 1)'(hebp_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == hebp_pkg::QA_W'(hebp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == hebp_pkg::QA_W'(hebp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/hebp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hebp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire hebp_pkg::chunk_t  q_chunk,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output hebp_pkg::out_t         result
);

  // Right-aligned bit accumulator; rem counts the live bits
  logic [hebp_pkg::WORK_W-1:0] work;
  logic [hebp_pkg::CNT_W-1:0]  rem;
  logic                        out_valid;
  hebp_pkg::out_t              out_reg;

  logic [hebp_pkg::WORK_W-1:0] work_next;
  logic [hebp_pkg::CNT_W-1:0]  rem_next;
  logic                        out_free;
  logic                        emit;
  logic [hebp_pkg::CNT_W-1:0]  rem_less;
  logic [hebp_pkg::CNT_W-1:0]  base_rem;
  logic [hebp_pkg::CNT_W-1:0]  pad_cnt;
  logic [hebp_pkg::CNT_W-1:0]  add_cnt;
  logic [hebp_pkg::VAL_W-1:0]  add_bits;
  logic [hebp_pkg::BUF_W-1:0]  keep_mask;
  logic [hebp_pkg::BUF_W-1:0]  keep;
  logic [hebp_pkg::WORK_W-1:0] shifted;
  logic                        take;

  // Byte emission: top eight live bits go to the output register
  assign out_free = !out_valid || pop;
  assign emit     = (rem >= hebp_pkg::CNT_W'(hebp_pkg::BYTE_W)) && out_free;
  assign rem_less = rem - hebp_pkg::CNT_W'(hebp_pkg::BYTE_W);
  assign shifted  = work >> rem_less;
  assign base_rem = emit ? rem_less : rem;

  // Next chunk joins the pending bits once fewer than a byte remain
  assign take     = q_valid && (base_rem < hebp_pkg::CNT_W'(hebp_pkg::BYTE_W));
  assign q_pop    = take;
  assign pad_cnt  = (base_rem == '0) ? '0 : hebp_pkg::CNT_W'(hebp_pkg::BYTE_W) - base_rem;
  assign add_cnt  = q_chunk.pad ? pad_cnt : q_chunk.count;
  assign add_bits = q_chunk.pad ? '0 : q_chunk.bits;
  assign keep_mask = ~({hebp_pkg::BUF_W{1'b1}} << base_rem);
  assign keep      = work[hebp_pkg::BUF_W-1:0] & keep_mask;

  always_comb begin
    work_next = work;
    rem_next  = base_rem;
    if (take) begin
      work_next = (hebp_pkg::WORK_W'(keep) << add_cnt) | hebp_pkg::WORK_W'(add_bits);
      rem_next  = base_rem + add_cnt;
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
  end

  // Control: live bit count and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      rem <= rem_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Last byte of an item: fewer than a byte stays behind
  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= '{out_byte: shifted[hebp_pkg::BYTE_W-1:0],
                   last_of_run: rem_less < hebp_pkg::CNT_W'(hebp_pkg::BYTE_W)};
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

`default_nettype wire

// File: design/huffman_encode_bit_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Huffman encoder with MSB-first bit packer. Each input beat loads a code
// table entry, encodes a byte symbol through the table, pads to a byte
// boundary, or appends up to 32 raw bits; every completed byte comes out as
// one result beat, and last_of_run marks the final byte an input beat caused.
// The front takes one input beat per clock while the queue has room; the table
// read is registered and the beat then waits in a four-entry work queue. The
// packer emits one byte per clock while results are popped, and takes the next
// item once fewer than a byte is pending (table loads never reach it); input
// stalls only when that queue fills. A beat passes the lookup stage, the work
// queue, the packer's accumulator and its output register. The table is
// cleared by reset with no clearing pass: unloaded symbols encode to nothing.
module huffman_encode_bit_packer_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire hebp_pkg::in_t   item,
  output logic                 empty,
  input  wire logic            pop,
  output hebp_pkg::out_t       result
);

  logic               chunk_valid;
  hebp_pkg::chunk_t   chunk;
  logic               q_ready;
  logic               q_valid;
  hebp_pkg::chunk_t   q_chunk;
  logic               q_pop;

  hebp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .chunk_valid (chunk_valid),
    .chunk       (chunk),
    .q_ready     (q_ready)
  );

  hebp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (chunk_valid),
    .wr_data  (chunk),
    .wr_ready (q_ready),
    .rd_valid (q_valid),
    .rd_data  (q_chunk),
    .rd_pop   (q_pop)
  );

  hebp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_chunk (q_chunk),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

`ifndef SYNTH
  // Append work never carries more than one raw run
  a_chunk_len: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !chunk.pad |-> chunk.count <= hebp_pkg::CNT_W'(hebp_pkg::RAW_MAX))
    else $error("append chunk longer than a raw run");

  // Input stalls only because the work queue is full
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_ready && chunk_valid)
    else $error("input stalled with room in the work queue");

  // Packer only takes work it can see
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("work queue popped while empty");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result waiting after reset");
`endif

endmodule

`default_nettype wire
